// ----- src/qvr_pkg.sv -----
// qvr_pkg: widths shared by the quaternion vector rotation block
// no dependencies
package qvr_pkg;
  localparam int FIELD_W = 16;
  localparam int PROD_W  = 32;
  localparam int N2_W    = 33;
  localparam int SUM_W   = 34;
  localparam int TERM_W  = 50;
  localparam int NUM_W   = 56;
  localparam int QBITS   = 17;
  localparam int LANES   = 3;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [NUM_W-1:0]   num_t;
  typedef logic [NUM_W-1:0]          mag_t;
  typedef logic [N2_W-1:0]           den_t;
  typedef logic [QBITS-1:0]          quo_t;

  localparam logic [QBITS-1:0] POS_MAX = QBITS'(32767);
  localparam logic [QBITS-1:0] NEG_MAX = QBITS'(32768);
endpackage

// ----- src/quaternion_vector_rotate.sv -----
// quaternion_vector_rotate: rotates a q8.8 vector by a normalized q2.14 quaternion
// depends on qvr_pkg
//
// usage: drive the seven input fields and raise start for one cycle per
// transaction. busy is always low, so a transaction can be started in every
// cycle. each transaction produces one result, shown on rot_x, rot_y, rot_z,
// zero_quat_error and saturated for exactly one cycle while done is high.
// throughput is one transaction per cycle.
// the pipeline: four stages of products and sums build the numerator and
// n2, one stage forms the rounded magnitude, 17 restoring divide stages (one
// quotient bit each, three lanes) divide by n2, and an output register
// saturates and signs the quotient.
// an all-zero quaternion gives a zero vector with zero_quat_error set.
// synchronous reset clears all valid bits; transactions in flight are lost.
// the receiver cannot stall, so results are never held.
module quaternion_vector_rotate (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  qvr_pkg::field_t        quat_x,
  input  qvr_pkg::field_t        quat_y,
  input  qvr_pkg::field_t        quat_z,
  input  qvr_pkg::field_t        quat_w,
  input  qvr_pkg::field_t        vec_x,
  input  qvr_pkg::field_t        vec_y,
  input  qvr_pkg::field_t        vec_z,
  output logic                   done,
  output qvr_pkg::field_t        rot_x,
  output qvr_pkg::field_t        rot_y,
  output qvr_pkg::field_t        rot_z,
  output logic                   zero_quat_error,
  output logic                   saturated
);
  import qvr_pkg::*;

  assign busy = 1'b0;

  // stage 1: products
  logic  s1_valid;
  prod_t s1_xx, s1_yy, s1_zz, s1_ww;
  prod_t s1_xv, s1_yv, s1_zv;
  prod_t s1_yvz, s1_zvy, s1_zvx, s1_xvz, s1_xvy, s1_yvx;
  field_t s1_x, s1_y, s1_z, s1_w, s1_vx, s1_vy, s1_vz;

  // stage 2: sums
  logic  s2_valid;
  den_t  s2_n2;
  sum_t  s2_s, s2_d, s2_cx, s2_cy, s2_cz;
  field_t s2_x, s2_y, s2_z, s2_w, s2_vx, s2_vy, s2_vz;

  // stage 3: terms
  logic  s3_valid;
  den_t  s3_n2;
  term_t s3_sv [LANES];
  term_t s3_du [LANES];
  term_t s3_wc [LANES];

  // stage 4: numerator
  logic  s4_valid;
  den_t  s4_n2;
  num_t  s4_num [LANES];

  // divider pipeline, index 0 is the rounded magnitude stage
  logic [QBITS:0] dv_valid;
  den_t           dv_den  [0:QBITS];
  logic           dv_zero [0:QBITS];
  logic [LANES-1:0] dv_neg [0:QBITS];
  logic [LANES-1:0] dv_big [0:QBITS];
  mag_t           dv_rem  [0:QBITS][LANES];
  quo_t           dv_quo  [0:QBITS][LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      dv_valid <= '0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      dv_valid <= {dv_valid[QBITS-1:0], s4_valid};
      done     <= dv_valid[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    s1_xx  <= quat_x * quat_x;
    s1_yy  <= quat_y * quat_y;
    s1_zz  <= quat_z * quat_z;
    s1_ww  <= quat_w * quat_w;
    s1_xv  <= quat_x * vec_x;
    s1_yv  <= quat_y * vec_y;
    s1_zv  <= quat_z * vec_z;
    s1_yvz <= quat_y * vec_z;
    s1_zvy <= quat_z * vec_y;
    s1_zvx <= quat_z * vec_x;
    s1_xvz <= quat_x * vec_z;
    s1_xvy <= quat_x * vec_y;
    s1_yvx <= quat_y * vec_x;
    s1_x <= quat_x; s1_y <= quat_y; s1_z <= quat_z; s1_w <= quat_w;
    s1_vx <= vec_x; s1_vy <= vec_y; s1_vz <= vec_z;
  end

  sum_t s1_uu, s1_n2s;
  assign s1_uu  = SUM_W'(s1_xx) + SUM_W'(s1_yy) + SUM_W'(s1_zz);
  assign s1_n2s = s1_uu + SUM_W'(s1_ww);

  always_ff @(posedge clk) begin
    s2_n2 <= N2_W'(s1_n2s);
    s2_s  <= SUM_W'(s1_ww) - s1_uu;
    s2_d  <= SUM_W'(s1_xv) + SUM_W'(s1_yv) + SUM_W'(s1_zv);
    s2_cx <= SUM_W'(s1_yvz) - SUM_W'(s1_zvy);
    s2_cy <= SUM_W'(s1_zvx) - SUM_W'(s1_xvz);
    s2_cz <= SUM_W'(s1_xvy) - SUM_W'(s1_yvx);
    s2_x <= s1_x; s2_y <= s1_y; s2_z <= s1_z; s2_w <= s1_w;
    s2_vx <= s1_vx; s2_vy <= s1_vy; s2_vz <= s1_vz;
  end

  always_ff @(posedge clk) begin
    s3_n2    <= s2_n2;
    s3_sv[0] <= TERM_W'(s2_s * s2_vx);
    s3_sv[1] <= TERM_W'(s2_s * s2_vy);
    s3_sv[2] <= TERM_W'(s2_s * s2_vz);
    s3_du[0] <= TERM_W'(s2_d * s2_x);
    s3_du[1] <= TERM_W'(s2_d * s2_y);
    s3_du[2] <= TERM_W'(s2_d * s2_z);
    s3_wc[0] <= TERM_W'(s2_cx * s2_w);
    s3_wc[1] <= TERM_W'(s2_cy * s2_w);
    s3_wc[2] <= TERM_W'(s2_cz * s2_w);
  end

  always_ff @(posedge clk) begin
    s4_n2 <= s3_n2;
    for (int i = 0; i < LANES; i++) begin
      s4_num[i] <= NUM_W'(s3_sv[i]) + (NUM_W'(s3_du[i]) <<< 1)
                 + (NUM_W'(s3_wc[i]) <<< 1);
    end
  end

  // rounded magnitude: |num| + n2/2
  always_ff @(posedge clk) begin
    dv_den[0]  <= s4_n2;
    dv_zero[0] <= (s4_n2 == '0);
    dv_big[0]  <= '0;
    for (int i = 0; i < LANES; i++) begin
      dv_neg[0][i] <= s4_num[i][NUM_W-1];
      dv_rem[0][i] <= (s4_num[i][NUM_W-1] ? mag_t'(-s4_num[i]) : mag_t'(s4_num[i]))
                    + NUM_W'(s4_n2 >> 1);
      dv_quo[0][i] <= '0;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    localparam int SH = QBITS - 1 - k;
    mag_t trial;
    mag_t limit;
    assign trial = NUM_W'(dv_den[k]) << SH;
    assign limit = NUM_W'(dv_den[k]) << QBITS;

    always_ff @(posedge clk) begin
      dv_den[k+1]  <= dv_den[k];
      dv_zero[k+1] <= dv_zero[k];
      dv_neg[k+1]  <= dv_neg[k];
      for (int i = 0; i < LANES; i++) begin
        if (k == 0) begin
          dv_big[k+1][i] <= (dv_rem[k][i] >= limit);
        end else begin
          dv_big[k+1][i] <= dv_big[k][i];
        end
        if (dv_rem[k][i] >= trial) begin
          dv_rem[k+1][i] <= dv_rem[k][i] - trial;
          dv_quo[k+1][i] <= dv_quo[k][i] | (QBITS'(1) << SH);
        end else begin
          dv_rem[k+1][i] <= dv_rem[k][i];
          dv_quo[k+1][i] <= dv_quo[k][i];
        end
      end
    end
  end

  // saturate and sign
  field_t         res [LANES];
  logic [LANES-1:0] clip;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (dv_neg[QBITS][i]) begin
        clip[i] = dv_big[QBITS][i] || (dv_quo[QBITS][i] > NEG_MAX);
        res[i]  = clip[i] ? field_t'(-32768)
                          : FIELD_W'(-$signed({1'b0, dv_quo[QBITS][i]}));
      end else begin
        clip[i] = dv_big[QBITS][i] || (dv_quo[QBITS][i] > POS_MAX);
        res[i]  = clip[i] ? field_t'(32767) : FIELD_W'(dv_quo[QBITS][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dv_zero[QBITS]) begin
      rot_x           <= '0;
      rot_y           <= '0;
      rot_z           <= '0;
      zero_quat_error <= 1'b1;
      saturated       <= 1'b0;
    end else begin
      rot_x           <= res[0];
      rot_y           <= res[1];
      rot_z           <= res[2];
      zero_quat_error <= 1'b0;
      saturated       <= |clip;
    end
  end

  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(zero_quat_error && saturated))
    else $error("error and saturation both set");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (done && zero_quat_error) |-> (rot_x == '0 && rot_y == '0 && rot_z == '0))
    else $error("zero quaternion gave nonzero vector");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (rot_x == 16'sh7fff || rot_x == 16'sh8000 ||
                             rot_y == 16'sh7fff || rot_y == 16'sh8000 ||
                             rot_z == 16'sh7fff || rot_z == 16'sh8000))
    else $error("saturation flagged without a clipped component");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(dv_valid[QBITS]))
    else $error("done without a transaction in the last divide stage");
endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking testbench for quaternion_vector_rotate
// depends on qvr_pkg and the quaternion_vector_rotate rtl
`timescale 1ns / 100ps

module tb_top;
  import qvr_pkg::*;

  typedef struct {
    field_t qx, qy, qz, qw, vx, vy, vz;
  } rot_item_t;

  typedef struct {
    field_t rx, ry, rz;
    logic   zerr, sat;
  } rot_result_t;

  localparam int LATENCY   = 23;
  localparam int WDOG_MAX  = 2000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  field_t quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  field_t vec_x = '0, vec_y = '0, vec_z = '0;
  logic   busy, done, zero_quat_error, saturated;
  field_t rot_x, rot_y, rot_z;

  rot_item_t   pending_q[$];
  rot_result_t rot_expect_q[$];
  int          idle_pct = 0;
  bit          hold_off = 1'b0;
  int          errors = 0;
  int          wdog = 0;

  always #6 clk = ~clk;

  quaternion_vector_rotate u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .done(done), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
    .zero_quat_error(zero_quat_error), .saturated(saturated)
  );

  function automatic field_t round_div_sat(longint num, longint den, inout logic sat);
    longint mag, qt;
    bit     neg;
    neg = num < 0;
    mag = neg ? -num : num;
    qt  = (mag + den / 2) / den;
    if (!neg) begin
      if (qt > 32767) begin qt = 32767; sat = 1'b1; end
      return field_t'(qt);
    end
    if (qt > 32768) begin qt = 32768; sat = 1'b1; end
    return field_t'(-qt);
  endfunction

  function automatic rot_result_t rotate_vector(rot_item_t it);
    rot_result_t r;
    longint x, y, z, w, vx, vy, vz, uu, n2, s, d, cx, cy, cz;
    logic   sat;
    x = it.qx; y = it.qy; z = it.qz; w = it.qw;
    vx = it.vx; vy = it.vy; vz = it.vz;
    uu = x*x + y*y + z*z;
    n2 = uu + w*w;
    r = '{rx: '0, ry: '0, rz: '0, zerr: 1'b1, sat: 1'b0};
    if (n2 == 0) return r;
    s  = w*w - uu;
    d  = x*vx + y*vy + z*vz;
    cx = y*vz - z*vy;
    cy = z*vx - x*vz;
    cz = x*vy - y*vx;
    sat = 1'b0;
    r.rx = round_div_sat(s*vx + 2*d*x + 2*w*cx, n2, sat);
    r.ry = round_div_sat(s*vy + 2*d*y + 2*w*cy, n2, sat);
    r.rz = round_div_sat(s*vz + 2*d*z + 2*w*cz, n2, sat);
    r.zerr = 1'b0;
    r.sat = sat;
    return r;
  endfunction

  function automatic field_t rand_field(int mode);
    case (mode)
      0: return field_t'($urandom);
      1: return field_t'($urandom_range(0, 6) - 3);
      2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      default: return field_t'($urandom_range(0, 8192) - 4096);
    endcase
  endfunction

  task automatic push_item(int qx, int qy, int qz, int qw, int vx, int vy, int vz);
    rot_item_t it;
    it = '{field_t'(qx), field_t'(qy), field_t'(qz), field_t'(qw),
           field_t'(vx), field_t'(vy), field_t'(vz)};
    pending_q.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin
    rot_item_t it;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rot_expect_q.push_back(rotate_vector('{quat_x, quat_y, quat_z, quat_w,
                                               vec_x, vec_y, vec_z}));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_q.size() > 0 && !hold_off &&
                   $urandom_range(0, 99) >= idle_pct) begin
        it = pending_q.pop_front();
        quat_x <= it.qx; quat_y <= it.qy; quat_z <= it.qz; quat_w <= it.qw;
        vec_x <= it.vx; vec_y <= it.vy; vec_z <= it.vz;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rot_result_t e;
    if (!rst && done) begin
      if (rot_expect_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        e = rot_expect_q.pop_front();
        if (rot_x !== e.rx) begin
          $error("rot_x expected %0d actual %0d", e.rx, rot_x); errors++;
        end
        if (rot_y !== e.ry) begin
          $error("rot_y expected %0d actual %0d", e.ry, rot_y); errors++;
        end
        if (rot_z !== e.rz) begin
          $error("rot_z expected %0d actual %0d", e.rz, rot_z); errors++;
        end
        if (zero_quat_error !== e.zerr) begin
          $error("zero_quat_error expected %0b actual %0b", e.zerr, zero_quat_error);
          errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated expected %0b actual %0b", e.sat, saturated); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int m;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed
    push_item(0, 0, 0, 0, 100, -100, 32767);
    push_item(0, 0, 0, 0, 0, 0, 0);
    push_item(0, 0, 0, 16384, 256, -512, 768);
    push_item(0, 0, 0, 16384, 32767, -32768, 32767);
    push_item(16384, 0, 0, 0, 256, 512, 768);
    push_item(0, 16384, 0, 0, 256, 512, 768);
    push_item(0, 0, 16384, 0, 256, 512, 768);
    push_item(11585, 0, 0, 11585, 32767, 32767, 32767);
    push_item(0, 0, 11585, 11585, 32767, 32767, -32768);
    push_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
    push_item(32767, 32767, 32767, 32767, 32767, 32767, 32767);
    push_item(32767, -32768, 32767, -32768, -32768, 32767, -32768);
    push_item(1, 0, 0, 0, 1, 1, 1);
    push_item(0, 0, 0, -1, -1, 0, 1);
    push_item(1, 1, 1, 1, 3, -3, 1);
    push_item(8192, 8192, 8192, 8192, 23170, 23170, 23170);
    push_item(3, 5, 7, 0, -32768, 32767, 1);
    push_item(0, 0, 0, 1, 0, 0, 0);
    wait (pending_q.size() == 0);
    // sender pause until everything has drained
    hold_off = 1'b1;
    wait (rot_expect_q.size() == 0 && !start);
    hold_off = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 64;
        2: idle_pct = 0;
        default: idle_pct = 29;
      endcase
      for (int i = 0; i < 500; i++) begin
        m = $urandom_range(0, 9);
        if (m == 0) begin
          push_item(0, 0, 0, 0, rand_field(0), rand_field(0), rand_field(0));
        end else begin
          m = (m < 6) ? 0 : m - 5;
          push_item(rand_field(m), rand_field(m), rand_field(m), rand_field(m),
                    rand_field($urandom_range(0, 3)), rand_field($urandom_range(0, 3)),
                    rand_field($urandom_range(0, 3)));
        end
      end
      wait (pending_q.size() == 0);
    end
    wait (rot_expect_q.size() == 0 && !start);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
